FILE: src/ntc_thermistor_temperature_macros.svh
`ifndef NTC_THERMISTOR_TEMPERATURE_MACROS_SVH
`define NTC_THERMISTOR_TEMPERATURE_MACROS_SVH
// Assertion on clk_i, held off while rst_ni is low.
`define NTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen.
`define NTC_NEVER(lbl, cond, msg) \
  `NTC_ASSERT(lbl, !(cond), msg)
`endif

FILE: src/ntc_pkg.sv
`timescale 1ns / 1ps
package ntc_pkg;

  localparam int SAMPLES = 10;
  localparam int SMP_W   = $clog2(SAMPLES + 1);
  localparam int SUM_W   = 18;
  localparam int CNT_W   = 6;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 24;
  localparam int PR_W    = 24 + SUM_W;      // resistor times reading
  localparam int E_W     = $clog2(PR_W);    // integer part of log2
  localparam int LOG_W   = E_W + 32;        // log2 in Q32
  localparam int LN_W    = LOG_W + 1;       // ln magnitude in Q32
  localparam int DVD_W   = 48;
  localparam int DVS_W   = 40;
  localparam int TC_W    = 34;              // centi-C Q8, +-2^32
  localparam int PRD_W   = TC_W + 17;
  localparam int S_W     = PRD_W - 16;
  localparam int RQ_W    = 14;
  localparam int MEAN_SH = 28;              // mean reciprocal shift
  localparam int TEN_SH  = 22;              // tenth reciprocal shift

  localparam logic [31:0]       LN2_Q32     = 32'd2977044472;
  localparam logic [23:0]       INV_NOM_Q32 = 24'((64'd100 << 32) / 64'd29815);
  localparam logic [46:0]       T_NUM       = 47'd100 << 40;
  localparam logic [22:0]       KC_OFS      = 23'd6992640;       // 273.15 K in centi Q8
  localparam logic [17:0]       RND_OFS     = 18'd65540;         // 10 * 6554
  localparam logic [18:0]       TEN_RCP     = 19'd419431;        // ceil(2^22 / 10)
  localparam logic [28:0]       MEAN_RCP    =
    29'(((64'd1 << MEAN_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
  localparam logic [TC_W-1:0]   TC_CLAMP    = TC_W'(64'd1 << 32);
  localparam logic [SUM_W-1:0]  LO_LIM      = SUM_W'(10 * SAMPLES);

  typedef enum logic [IDX_W-1:0] {
    REG_SERIES  = 3'd0,
    REG_NOMINAL = 3'd1,
    REG_BETA    = 3'd2,
    REG_SCALE   = 3'd3,
    REG_REVERSE = 3'd4,
    REG_ROUND   = 3'd5,
    REG_FULL    = 3'd6
  } reg_e;

  typedef enum logic [3:0] {
    CMD_NOP, CMD_ACC, CMD_PRA, CMD_PRB, CMD_RES_GO, CMD_MEAN_GO, CMD_LOGA_GO,
    CMD_LOGB_GO, CMD_LNH, CMD_LNL, CMD_Q_GO, CMD_T_GO, CMD_T_CLAMP, CMD_MUL,
    CMD_RND_GO, CMD_EMIT
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_PRB, ST_RES, ST_RES_W, ST_MEAN, ST_LOGA,
    ST_LOGA_W, ST_LOGB, ST_LOGB_W, ST_LNH, ST_LNL, ST_Q, ST_Q_W, ST_TSEL,
    ST_T_W, ST_MUL, ST_RND, ST_EMIT
  } st_e;

  typedef enum logic [1:0] {DS_RES, DS_Q, DS_T} div_sel_e;

  typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_SQ} lg_ph_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic in_win;
    logic inv_pos;
    logic rnd;
    logic div_done;
    logic log_done;
    logic out_free;
  } stat_t;

endpackage

FILE: src/ntc_ctrl.sv
`timescale 1ns / 1ps
module ntc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  ntc_pkg::stat_t stat_i,
  output ntc_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import ntc_pkg::*;

  st_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d      = st_q;
    cmd_o.op  = CMD_NOP;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_ACC;
          if (stat_i.last) st_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (stat_i.in_win) begin
          cmd_o.op = CMD_PRA;
          st_d     = ST_PRB;
        end else begin
          st_d = ST_EMIT;
        end
      end
      ST_PRB: begin
        cmd_o.op = CMD_PRB;
        st_d     = ST_RES;
      end
      ST_RES: begin
        cmd_o.op = CMD_RES_GO;
        st_d     = ST_RES_W;
      end
      ST_RES_W: if (stat_i.div_done) st_d = ST_MEAN;
      ST_MEAN: begin
        cmd_o.op = CMD_MEAN_GO;
        st_d     = ST_LOGA;
      end
      ST_LOGA: begin
        cmd_o.op = CMD_LOGA_GO;
        st_d     = ST_LOGA_W;
      end
      ST_LOGA_W: if (stat_i.log_done) st_d = ST_LOGB;
      ST_LOGB: begin
        cmd_o.op = CMD_LOGB_GO;
        st_d     = ST_LOGB_W;
      end
      ST_LOGB_W: if (stat_i.log_done) st_d = ST_LNH;
      ST_LNH: begin
        cmd_o.op = CMD_LNH;
        st_d     = ST_LNL;
      end
      ST_LNL: begin
        cmd_o.op = CMD_LNL;
        st_d     = ST_Q;
      end
      ST_Q: begin
        cmd_o.op = CMD_Q_GO;
        st_d     = ST_Q_W;
      end
      ST_Q_W: if (stat_i.div_done) st_d = ST_TSEL;
      ST_TSEL: begin
        if (stat_i.inv_pos) begin
          cmd_o.op = CMD_T_GO;
          st_d     = ST_T_W;
        end else begin
          cmd_o.op = CMD_T_CLAMP;
          st_d     = ST_MUL;
        end
      end
      ST_T_W: if (stat_i.div_done) st_d = ST_MUL;
      ST_MUL: begin
        cmd_o.op = CMD_MUL;
        st_d     = stat_i.rnd ? ST_RND : ST_EMIT;
      end
      ST_RND: begin
        cmd_o.op = CMD_RND_GO;
        st_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = CMD_EMIT;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign busy_o = (st_q != ST_IDLE);

endmodule

FILE: src/ntc_div.sv
`timescale 1ns / 1ps
module ntc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ntc_pkg::DVD_W-1:0] dividend_i,
  input  logic [ntc_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ntc_pkg::DVD_W-1:0] quot_o
);
  import ntc_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DVS_W:0]   trial;

  // restoring, one quotient bit a cycle; quotient bits shift into dvd
  always_comb begin
    trial  = {rem_q, dvd_q[DVD_W-1]};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DVS_W'(trial - {1'b0, dvs_q});
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVS_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

FILE: src/ntc_dp.sv
`timescale 1ns / 1ps
module ntc_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ntc_pkg::cmd_t             cmd_i,
  output ntc_pkg::stat_t            stat_o,
  input  logic [11:0]               adc_sample_i,
  input  logic                      cfg_we_i,
  input  logic [ntc_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [ntc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic signed [15:0]        temperature_centi_o,
  output logic [31:0]               resistance_ohms_o,
  output logic [15:0]               mean_sample_x16_o,
  output logic                      valid_res_o
);
  import ntc_pkg::*;

  localparam int HL_W = 15 + SMP_W;
  localparam int RS_W = 12 + SMP_W;

  // configuration
  logic [23:0] ser_q, ser_d, nom_q, nom_d;
  logic [15:0] beta_q, beta_d, scale_q, scale_d;
  logic        rev_q, rev_d, rnd_q, rnd_d;
  logic [11:0] full_q, full_d;

  // accumulation
  logic [SUM_W-1:0] sum_q, sum_d, sumc_q, sumc_d, acc;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last;

  // working registers
  logic [SUM_W-1:0]  diff_q, diff_d;
  logic [PR_W-1:0]   pa_q, pa_d, pb_q, pb_d;
  logic [31:0]       res_q, res_d;
  logic [15:0]       mean_q, mean_d;
  logic [LOG_W-1:0]  la_q, la_d, lb_q, lb_d;
  logic              neg_q, neg_d;
  logic [53:0]       phi_q, phi_d;
  logic [15:0]       lo_q, lo_d;
  logic [LN_W-1:0]   lnm_q, lnm_d, q_q, q_d;
  logic signed [TC_W-1:0]  tc_q, tc_d;
  logic signed [PRD_W-1:0] prod_q, prod_d;
  logic [RQ_W-1:0]   rq_q, rq_d;
  div_sel_e          dsel_q, dsel_d;

  // log2 unit
  lg_ph_e            lg_ph_q, lg_ph_d;
  logic [PR_W-1:0]   lg_n_q, lg_n_d;
  logic [E_W-1:0]    lg_e_q, lg_e_d;
  logic [30:0]       lg_m_q, lg_m_d;
  logic [27:0]       lg_f_q, lg_f_d;
  logic [4:0]        lg_i_q, lg_i_d;
  logic              lg_b_q, lg_b_d, lg_done_q, lg_done_d;
  logic [61:0]       sqp;
  logic [31:0]       sqt;
  logic [LOG_W-1:0]  lg_val;

  // output register
  logic              ov_q, ov_d, ovr_q, ovr_d;
  logic signed [15:0] ot_q, ot_d;
  logic [31:0]       or_q, or_d;
  logic [15:0]       om_q, om_d;

  // combinational helpers
  logic signed [13:0]     refm10;
  logic signed [HL_W-1:0] hi_lim;
  logic [RS_W-1:0]        refs;
  logic                   in_win, out_free, inv_pos;
  logic [23:0]            rs_eff, nom_eff;
  logic [15:0]            beta_eff;
  logic [PR_W-1:0]        num, den;
  logic [LOG_W-1:0]       mag;
  logic [47:0]            plo;
  logic [54:0]            lnsum;
  logic signed [40:0]     inv_w;
  logic signed [S_W-1:0]  s_w;
  logic signed [17:0]     s_cl;
  logic [17:0]            u_w;
  logic [36:0]            rqp;
  logic [50:0]            mp;
  logic signed [37:0]     rq10, c_w;
  logic [15:0]            c_sat;

  logic                   div_start, div_done;
  logic [DVD_W-1:0]       div_dvd, div_quot;
  logic [DVS_W-1:0]       div_dvs;

  ntc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    last     = (cnt_q == CNT_W'(SAMPLES - 1));
    acc      = sum_q + SUM_W'(adc_sample_i);
    refm10   = $signed({2'b00, full_q}) - 14'sd10;
    hi_lim   = $signed({{(HL_W - 14){refm10[13]}}, refm10}) * $signed(HL_W'(SAMPLES));
    in_win   = (sumc_q >= LO_LIM) &&
               ($signed({{(HL_W - SUM_W){1'b0}}, sumc_q}) <= hi_lim);
    refs     = RS_W'(full_q) * RS_W'(SAMPLES);
    out_free = !ov_q || !out_stall_i;
    rs_eff   = (ser_q == '0) ? 24'd1 : ser_q;
    nom_eff  = (nom_q == '0) ? 24'd1 : nom_q;
    beta_eff = (beta_q == '0) ? 16'd1 : beta_q;
    num      = rev_q ? pa_q : pb_q;
    den      = rev_q ? pb_q : pa_q;
    mag      = (la_q >= lb_q) ? (la_q - lb_q) : (lb_q - la_q);
    plo      = 48'(lo_q) * 48'(LN2_Q32);
    lnsum    = 55'(phi_q) + 55'(plo[47:16]);
    inv_w    = neg_q ? ($signed({17'b0, INV_NOM_Q32}) - $signed({2'b0, q_q}))
                     : ($signed({17'b0, INV_NOM_Q32}) + $signed({2'b0, q_q}));
    inv_pos  = !inv_w[40] && (inv_w != '0);
    s_w      = prod_q[PRD_W-1:16];
    // anything past +-65536 saturates anyway once floored to a tenth
    if (s_w > S_W'(65535)) s_cl = 18'sd65535;
    else if (s_w < -S_W'(65536)) s_cl = -18'sd65536;
    else s_cl = s_w[17:0];
    u_w      = 18'(s_cl) + RND_OFS;
    rqp      = 37'(u_w) * 37'(TEN_RCP);
    rq10     = $signed(38'(rq_q) * 38'd10) - $signed(38'(RND_OFS));
    c_w      = rnd_q ? rq10 : 38'(s_w);
    if (c_w > 38'sd32767) c_sat = 16'h7fff;
    else if (c_w < -38'sd32768) c_sat = 16'h8000;
    else c_sat = c_w[15:0];
    mp       = 51'({sumc_q, 4'b0000}) * 51'(MEAN_RCP);
    sqp      = 62'(lg_m_q) * 62'(lg_m_q);
    sqt      = sqp[61:30];
    lg_val   = {lg_e_q, lg_f_q, 4'b0000};
  end

  // divider operand select
  always_comb begin
    div_start = 1'b1;
    div_dvd   = '0;
    div_dvs   = DVS_W'(1);
    dsel_d    = dsel_q;
    case (cmd_i.op)
      CMD_RES_GO: begin
        div_dvd = DVD_W'(pa_q);
        div_dvs = DVS_W'(diff_q);
        dsel_d  = DS_RES;
      end
      CMD_Q_GO: begin
        div_dvd = DVD_W'(lnm_q);
        div_dvs = DVS_W'(beta_eff);
        dsel_d  = DS_Q;
      end
      CMD_T_GO: begin
        div_dvd = DVD_W'(T_NUM);
        div_dvs = inv_w[DVS_W-1:0];
        dsel_d  = DS_T;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    ser_d = ser_q;  nom_d = nom_q;  beta_d = beta_q;  scale_d = scale_q;
    rev_d = rev_q;  rnd_d = rnd_q;  full_d = full_q;
    sum_d = sum_q;  cnt_d = cnt_q;  sumc_d = sumc_q;
    diff_d = diff_q; pa_d = pa_q;   pb_d = pb_q;     res_d = res_q;
    mean_d = mean_q; la_d = la_q;   lb_d = lb_q;     neg_d = neg_q;
    phi_d = phi_q;  lo_d = lo_q;    lnm_d = lnm_q;   q_d = q_q;
    tc_d = tc_q;    prod_d = prod_q; rq_d = rq_q;
    lg_ph_d = lg_ph_q; lg_n_d = lg_n_q; lg_e_d = lg_e_q; lg_m_d = lg_m_q;
    lg_f_d = lg_f_q;   lg_i_d = lg_i_q; lg_b_d = lg_b_q; lg_done_d = 1'b0;
    ov_d = ov_q;    ovr_d = ovr_q;  ot_d = ot_q;     or_d = or_q;  om_d = om_q;

    if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_SERIES:  ser_d   = cfg_data_i;
        REG_NOMINAL: nom_d   = cfg_data_i;
        REG_BETA:    beta_d  = cfg_data_i[15:0];
        REG_SCALE:   scale_d = cfg_data_i[15:0];
        REG_REVERSE: rev_d   = cfg_data_i[0];
        REG_ROUND:   rnd_d   = cfg_data_i[0];
        REG_FULL:    full_d  = cfg_data_i[11:0];
        default: ;
      endcase
    end

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    case (cmd_i.op)
      CMD_ACC: begin
        if (last) begin
          sumc_d = acc;
          sum_d  = '0;
          cnt_d  = '0;
        end else begin
          sum_d = acc;
          cnt_d = cnt_q + 1'b1;
        end
      end
      CMD_PRA: begin
        diff_d = SUM_W'(refs - RS_W'(sumc_q));
        pa_d   = PR_W'(rs_eff) * PR_W'(sumc_q);
      end
      CMD_PRB: pb_d = PR_W'(nom_eff) * PR_W'(diff_q);
      CMD_MEAN_GO: mean_d = mp[MEAN_SH +: 16];
      CMD_LOGA_GO: begin
        lg_n_d  = num;
        lg_e_d  = E_W'(PR_W - 1);
        lg_b_d  = 1'b0;
        lg_ph_d = LG_NORM;
      end
      CMD_LOGB_GO: begin
        lg_n_d  = den;
        lg_e_d  = E_W'(PR_W - 1);
        lg_b_d  = 1'b1;
        lg_ph_d = LG_NORM;
      end
      CMD_LNH: begin
        neg_d = (la_q < lb_q);
        phi_d = 54'(mag[LOG_W-1:16]) * 54'(LN2_Q32);
        lo_d  = mag[15:0];
      end
      CMD_LNL: lnm_d = lnsum[54:16];
      CMD_T_CLAMP: tc_d = $signed(TC_CLAMP);
      CMD_MUL: prod_d = tc_q * $signed({1'b0, scale_q});
      CMD_RND_GO: rq_d = rqp[TEN_SH +: RQ_W];
      CMD_EMIT: begin
        ov_d  = 1'b1;
        ovr_d = in_win;
        ot_d  = in_win ? $signed(c_sat) : 16'sd0;
        or_d  = in_win ? res_q : 32'd0;
        om_d  = in_win ? mean_q : 16'd0;
      end
      default: ;
    endcase

    // log2: normalise one bit a cycle, then 28 squarings
    case (lg_ph_q)
      LG_NORM: begin
        if (lg_n_q[PR_W-1]) begin
          lg_m_d  = lg_n_q[PR_W-1 -: 31];
          lg_i_d  = '0;
          lg_ph_d = LG_SQ;
        end else begin
          lg_n_d = {lg_n_q[PR_W-2:0], 1'b0};
          lg_e_d = lg_e_q - 1'b1;
        end
      end
      LG_SQ: begin
        lg_m_d = sqt[31] ? sqt[31:1] : sqt[30:0];
        lg_f_d = {lg_f_q[26:0], sqt[31]};
        lg_i_d = lg_i_q + 1'b1;
        if (lg_i_q == 5'd27) begin
          lg_ph_d   = LG_IDLE;
          lg_done_d = 1'b1;
        end
      end
      default: ;
    endcase

    if (lg_done_q) begin
      if (lg_b_q) lb_d = lg_val;
      else        la_d = lg_val;
    end

    if (div_done) begin
      case (dsel_q)
        DS_RES:  res_d  = (div_quot[47:32] != '0) ? 32'hffff_ffff : div_quot[31:0];
        DS_Q:    q_d    = div_quot[LN_W-1:0];
        DS_T: begin
          // quotient never below zero, so only the hot side clamps
          if (div_quot > (48'(TC_CLAMP) + 48'(KC_OFS))) tc_d = $signed(TC_CLAMP);
          else tc_d = $signed(div_quot[TC_W-1:0] - TC_W'(KC_OFS));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_q     <= 24'd10000;
      nom_q     <= 24'd10000;
      beta_q    <= 16'd3950;
      scale_q   <= 16'd256;
      rev_q     <= 1'b0;
      rnd_q     <= 1'b0;
      full_q    <= 12'd4095;
      sum_q     <= '0;
      cnt_q     <= '0;
      lg_ph_q   <= LG_IDLE;
      lg_done_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      ser_q     <= ser_d;
      nom_q     <= nom_d;
      beta_q    <= beta_d;
      scale_q   <= scale_d;
      rev_q     <= rev_d;
      rnd_q     <= rnd_d;
      full_q    <= full_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      lg_ph_q   <= lg_ph_d;
      lg_done_q <= lg_done_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sumc_q <= sumc_d;  diff_q <= diff_d;  pa_q <= pa_d;    pb_q <= pb_d;
    res_q  <= res_d;   mean_q <= mean_d;  la_q <= la_d;    lb_q <= lb_d;
    neg_q  <= neg_d;   phi_q  <= phi_d;   lo_q <= lo_d;    lnm_q <= lnm_d;
    q_q    <= q_d;     tc_q   <= tc_d;    prod_q <= prod_d; rq_q <= rq_d;
    dsel_q <= dsel_d;
    lg_n_q <= lg_n_d;  lg_e_q <= lg_e_d;  lg_m_q <= lg_m_d; lg_f_q <= lg_f_d;
    lg_i_q <= lg_i_d;  lg_b_q <= lg_b_d;
    ovr_q  <= ovr_d;   ot_q   <= ot_d;    or_q <= or_d;    om_q <= om_d;
  end

  assign stat_o.last     = last;
  assign stat_o.in_win   = in_win;
  assign stat_o.inv_pos  = inv_pos;
  assign stat_o.rnd      = rnd_q;
  assign stat_o.div_done = div_done;
  assign stat_o.log_done = lg_done_q;
  assign stat_o.out_free = out_free;

  assign out_valid_o         = ov_q;
  assign valid_res_o         = ovr_q;
  assign temperature_centi_o = ot_q;
  assign resistance_ohms_o   = or_q;
  assign mean_sample_x16_o   = om_q;

endmodule

FILE: src/ntc_thermistor_temperature.sv
`timescale 1ns / 1ps
// NTC thermistor temperature from averaged divider readings, beta equation with
// the nominal point at 25 C. Raw 12-bit readings are summed; every SAMPLES-th
// item yields one result: mean x16, divider resistance in ohms (saturated) and
// temperature in hundredths of a degree, scaled by a Q8.8 factor, optionally
// floored to tenths, saturated to 16 bits. A mean outside [10, full scale - 10]
// gives valid_res 0 with all other fields zero. Items that only accumulate do
// not stall the input. The closing item of a group keeps the input stalled
// while the result is worked out: one shared radix-2 divider does the
// resistance, ln/beta and reciprocal divides, and one log2 unit (normalising
// bit by bit, then 28 squarings) runs twice; the mean and the tenth flooring
// use reciprocal multiplies. Out-of-window groups stall the input only through
// the window check and the emit step. The emit step also waits while a
// stalled result holds the output register. A finished result waits in the
// output register while the next group accumulates. The user must write
// registers through cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the block
// does not enforce this. Unknown indexes are ignored.
module ntc_thermistor_temperature (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [11:0]               adc_sample_i,
  input  logic                      cfg_we_i,
  input  logic [ntc_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [ntc_pkg::CFG_W-1:0] cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [15:0]        temperature_centi_o,
  output logic [31:0]               resistance_ohms_o,
  output logic [15:0]               mean_sample_x16_o,
  output logic                      valid_res_o
);
  import ntc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  // sequencer: one command a cycle to the datapath
  ntc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // accumulator, config, divider, log2 unit and output register
  ntc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .adc_sample_i        (adc_sample_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .temperature_centi_o (temperature_centi_o),
    .resistance_ohms_o   (resistance_ohms_o),
    .mean_sample_x16_o   (mean_sample_x16_o),
    .valid_res_o         (valid_res_o)
  );

  // items are taken only while the sequencer is idle
  assign in_stall_o = busy;

endmodule

FILE: src/ntc_chk.sv
`timescale 1ns / 1ps
`include "ntc_thermistor_temperature_macros.svh"
module ntc_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [11:0]               adc_sample_i,
  input logic                      cfg_we_i,
  input logic [ntc_pkg::IDX_W-1:0] cfg_idx_i,
  input logic [ntc_pkg::CFG_W-1:0] cfg_data_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [15:0]        temperature_centi_o,
  input logic [31:0]               resistance_ohms_o,
  input logic [15:0]               mean_sample_x16_o,
  input logic                      valid_res_o
);

  // stalled result stays
  `NTC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")

  // out-of-window result carries zeros
  `NTC_NEVER(a_bad_zero, out_valid_o && !valid_res_o && (temperature_centi_o != 16'sd0 || resistance_ohms_o != 32'd0 || mean_sample_x16_o != 16'd0), "invalid result not zeroed")

  // a good mean is at least ten counts
  `NTC_ASSERT(a_mean_low, out_valid_o && valid_res_o |-> mean_sample_x16_o >= 16'd160, "valid mean below window")

  // a new result only comes out of a busy sequencer
  `NTC_ASSERT(a_emit_busy, $rose(out_valid_o) |-> $past(in_stall_o), "result without computation")

endmodule

bind ntc_thermistor_temperature ntc_chk u_chk (.*);
